// ===== hdl/pidtw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidtw_pkg
// Types, register codes and constants shared by the PID controller with
// twiddle gain tuning.
// ----------------------------------------------------------------------------
package pidtw_pkg;

	typedef logic signed [23:0] err_t;
	typedef logic signed [31:0] gain_t;
	typedef logic signed [31:0] drive_t;
	typedef logic signed [39:0] integ_t;
	typedef logic signed [24:0] delta_t;
	typedef logic [31:0]        cfg_data_t;

	typedef enum logic [2:0] {
		REG_KP_START     = 3'd0,
		REG_KI_START     = 3'd1,
		REG_KD_START     = 3'd2,
		REG_TUNE_ENABLE  = 3'd3,
		REG_WARMUP_STEPS = 3'd4,
		REG_EVAL_STEPS   = 3'd5,
		REG_SETTLE_STEPS = 3'd6
	} cfg_reg_t;

	typedef logic [2:0] cfg_idx_t;

	localparam logic        TUNE_ENABLE_RST  = 1'b1;
	localparam logic [15:0] WARMUP_STEPS_RST = 16'd900;
	localparam logic [15:0] EVAL_STEPS_RST   = 16'd1200;
	localparam logic [15:0] SETTLE_STEPS_RST = 16'd100;
	localparam logic [1:0]  GAIN_SEL_RST     = 2'd2;

	localparam logic [31:0] GAIN_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] GAIN_MIN = 32'h8000_0000;

	// ceil(2^35 / 10): exact quotient by ten for any 32-bit unsigned value.
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;

	// Payload handed from the state stage to the drive datapath.
	typedef struct packed {
		err_t   err;
		delta_t delta;
		integ_t integ;
		gain_t  gain_p;
		gain_t  gain_i;
		gain_t  gain_d;
		logic   changed;
	} s2_data_t;

	function automatic gain_t sat_to_32(input logic signed [63:0] v);
		gain_t r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = GAIN_MAX;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = GAIN_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/pidtw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidtw_if
// Valid/ready channels of the PID controller: error samples in, results out,
// and the register write channel.
// ----------------------------------------------------------------------------
interface pidtw_sample_if;
	logic              valid;
	logic              ready;
	pidtw_pkg::err_t   error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink   (input valid, input error_sample, output ready);
endinterface

interface pidtw_result_if;
	logic              valid;
	logic              ready;
	pidtw_pkg::drive_t drive;
	pidtw_pkg::gain_t  gain_p;
	pidtw_pkg::gain_t  gain_i;
	pidtw_pkg::gain_t  gain_d;
	logic              gains_changed;

	modport source (output valid, output drive, output gain_p, output gain_i,
		output gain_d, output gains_changed, input ready);
	modport sink   (input valid, input drive, input gain_p, input gain_i,
		input gain_d, input gains_changed, output ready);
endinterface

interface pidtw_cfg_if;
	logic                 valid;
	logic                 ready;
	pidtw_pkg::cfg_idx_t  index;
	pidtw_pkg::cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pidtw_div10.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidtw_div10
// Unsigned divide by ten through a reciprocal multiply, with a flag for a
// nonzero remainder; the 28-bit quotient is exact for magnitudes up to 2^31.
// ----------------------------------------------------------------------------
module pidtw_div10 (
	input  logic [31:0] mag,
	output logic [27:0] quot,
	output logic        rem_nz
);

	logic [63:0] prod;
	logic [31:0] back;

	assign prod   = 64'(mag) * 64'(pidtw_pkg::DIV10_MAGIC);
	assign quot   = prod[pidtw_pkg::DIV10_SHIFT +: 28];
	assign back   = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
	assign rem_nz = (back != mag);

endmodule

// ===== hdl/pidtw_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidtw_state
// Input register, configuration registers and the per-sample state update:
// integral, previous error, warm-up and period counting, squared error sum
// and the twiddle step on the gains.
// ----------------------------------------------------------------------------
module pidtw_state (
	input  logic                   clk,
	input  logic                   arst_n,
	pidtw_sample_if.sink           sample,
	pidtw_cfg_if.sink              cfg,
	output pidtw_pkg::s2_data_t    s2_data,
	output logic                   s2_valid,
	input  logic                   s2_ready
);

	// Stage 1: registered sample.
	logic              v_s1;
	pidtw_pkg::err_t   e_s1;
	logic signed [47:0] sq_full;

	// Stage 2 flags.
	logic              v_s2;
	pidtw_pkg::delta_t delta_s2;
	logic              changed_s2;

	// Configuration.
	logic              tune_q;
	logic [15:0]       warmup_steps_q;
	logic [15:0]       eval_steps_q;
	logic [15:0]       settle_steps_q;

	// Controller and tuner state.
	pidtw_pkg::integ_t integ_q, integ_d;
	pidtw_pkg::err_t   prev_q;
	pidtw_pkg::gain_t  gain_q [3];
	pidtw_pkg::gain_t  gain_d [3];
	pidtw_pkg::gain_t  trial_q [3];
	pidtw_pkg::gain_t  trial_d [3];
	logic [1:0]        sel_q, sel_d;
	logic              up_q, up_d;
	logic              down_q, down_d;
	logic [63:0]       psum_q, psum_d;
	logic [63:0]       best_q, best_d;
	logic [15:0]       warm_q, warm_d;
	logic [16:0]       pcount_q, pcount_d;
	logic              first_q, first_d;

	logic              s2_free;
	logic              fire12;
	logic              cfg_fire;

	logic signed [40:0] integ_sum;
	pidtw_pkg::integ_t  integ_sat;
	pidtw_pkg::delta_t  delta;
	logic               warm_done;
	logic [16:0]        period_len;
	logic [17:0]        pos_inc;
	logic [16:0]        pos;
	logic               in_eval;
	logic               period_end;
	logic               twiddle_go;
	logic [64:0]        psum_add;
	logic [63:0]        psum_sat;

	// Shared divide-by-ten path: start gains on a register write, otherwise
	// the trial step of the selected gain.
	logic [31:0]        dv_in;
	logic               dv_sign;
	logic [31:0]        dv_mag;
	logic [27:0]        quot;
	logic               rem_nz;
	logic [31:0]        tenth_mag;
	logic [31:0]        tenth;
	logic [32:0]        mag11;
	logic [31:0]        mag9;
	logic [31:0]        grow;
	logic [31:0]        shrink;

	logic               better;
	logic [1:0]         sel1;
	logic               up1;
	logic               down1;
	pidtw_pkg::gain_t   g_sel;
	pidtw_pkg::gain_t   t_sel;
	pidtw_pkg::gain_t   g_plus;
	pidtw_pkg::gain_t   g_minus2;

	function automatic logic [1:0] next_sel(input logic [1:0] s);
		return (s >= 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	assign s2_free      = !v_s2 || s2_ready;
	assign fire12       = v_s1 && s2_free;
	assign sample.ready = !v_s1 || s2_free;
	assign cfg.ready    = 1'b1;
	assign cfg_fire     = cfg.valid;

	assign sq_full = e_s1 * e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.ready) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			e_s1 <= sample.error_sample;
		end
	end

	// ---------------------------------------------------------------- update
	assign integ_sum = 41'(integ_q) + 41'(e_s1);
	assign integ_sat = (integ_sum[40] != integ_sum[39]) ?
		(integ_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}}) : integ_sum[39:0];
	assign delta     = 25'(e_s1) - 25'(prev_q);

	assign warm_done  = (warm_q >= warmup_steps_q);
	assign period_len = {1'b0, settle_steps_q} + {1'b0, eval_steps_q};
	assign pos_inc    = {1'b0, pcount_q} + 18'd1;
	assign pos        = (pos_inc >= {1'b0, period_len}) ? 17'd0 : pos_inc[16:0];
	assign in_eval    = warm_done && (pos > {1'b0, settle_steps_q});
	assign period_end = warm_done && (pos == 17'd0);
	assign twiddle_go = period_end && tune_q;

	// The square of the sample in stage 1 is never negative and fits 47 bits.
	assign psum_add = {1'b0, psum_q} + 65'(sq_full[46:0]);
	assign psum_sat = psum_add[64] ? {64{1'b1}} : psum_add[63:0];

	assign dv_in   = cfg_fire ? cfg.data : trial_q[sel_q];
	assign dv_sign = dv_in[31];
	assign dv_mag  = dv_sign ? (32'd0 - dv_in) : dv_in;

	pidtw_div10 u_div10 (
		.mag    (dv_mag),
		.quot   (quot),
		.rem_nz (rem_nz)
	);

	assign tenth_mag = {4'd0, quot};
	assign tenth     = dv_sign ? (32'd0 - tenth_mag) : tenth_mag;
	assign mag11     = {1'b0, dv_mag} + {1'b0, tenth_mag};
	assign mag9      = dv_mag - tenth_mag - 32'(rem_nz);
	assign shrink    = dv_sign ? (32'd0 - mag9) : mag9;

	always_comb begin
		if (!dv_sign) begin
			grow = (mag11 > {1'b0, pidtw_pkg::GAIN_MAX}) ? pidtw_pkg::GAIN_MAX : mag11[31:0];
		end else begin
			grow = (mag11 > {1'b0, pidtw_pkg::GAIN_MIN}) ? pidtw_pkg::GAIN_MIN :
				(32'd0 - mag11[31:0]);
		end
	end

	// A new best moves on to the next gain before the trial step is applied.
	assign better   = (psum_q < best_q);
	assign sel1     = better ? next_sel(sel_q) : sel_q;
	assign up1      = better ? 1'b0 : up_q;
	assign down1    = better ? 1'b0 : down_q;
	assign g_sel    = gain_q[sel1];
	assign t_sel    = trial_q[sel1];
	assign g_plus   = pidtw_pkg::sat_to_32(64'(g_sel) + 64'(t_sel));
	assign g_minus2 = pidtw_pkg::sat_to_32(64'(g_sel) - (64'(t_sel) <<< 1));

	always_comb begin
		integ_d = integ_q;
		sel_d   = sel_q;
		up_d    = up_q;
		down_d  = down_q;
		psum_d  = psum_q;
		best_d  = best_q;
		warm_d  = warm_q;
		pcount_d = pcount_q;
		first_d = first_q;
		for (int k = 0; k < 3; k++) begin
			gain_d[k]  = gain_q[k];
			trial_d[k] = trial_q[k];
		end

		if (fire12) begin
			integ_d = integ_sat;
			if (!warm_done) begin
				warm_d = warm_q + 16'd1;
			end else begin
				pcount_d = pos;
				if (in_eval) begin
					psum_d = psum_sat;
				end
				if (period_end) begin
					first_d = 1'b0;
				end
				if (twiddle_go) begin
					if (better) begin
						best_d = psum_q;
						if (!first_q) begin
							trial_d[sel_q] = grow;
						end
					end
					priority if (!up1 && !down1) begin
						gain_d[sel1] = g_plus;
						sel_d  = sel1;
						up_d   = 1'b1;
						down_d = 1'b0;
					end else if (up1 && !down1) begin
						gain_d[sel1] = g_minus2;
						sel_d  = sel1;
						up_d   = 1'b1;
						down_d = 1'b1;
					end else begin
						// Both directions failed: restore the gain and narrow
						// its step. Only reached without a new best, so the
						// selected gain is the one on the divider.
						gain_d[sel1]  = g_plus;
						trial_d[sel1] = shrink;
						sel_d  = next_sel(sel1);
						up_d   = 1'b0;
						down_d = 1'b0;
					end
					psum_d = '0;
				end
			end
		end

		if (cfg_fire) begin
			unique case (cfg.index)
				pidtw_pkg::REG_KP_START: begin
					gain_d[0]  = cfg.data;
					trial_d[0] = tenth;
				end
				pidtw_pkg::REG_KI_START: begin
					gain_d[1]  = cfg.data;
					trial_d[1] = tenth;
				end
				pidtw_pkg::REG_KD_START: begin
					gain_d[2]  = cfg.data;
					trial_d[2] = tenth;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_q         <= pidtw_pkg::TUNE_ENABLE_RST;
			warmup_steps_q <= pidtw_pkg::WARMUP_STEPS_RST;
			eval_steps_q   <= pidtw_pkg::EVAL_STEPS_RST;
			settle_steps_q <= pidtw_pkg::SETTLE_STEPS_RST;
		end else if (cfg_fire) begin
			unique case (cfg.index)
				pidtw_pkg::REG_TUNE_ENABLE:  tune_q         <= cfg.data[0];
				pidtw_pkg::REG_WARMUP_STEPS: warmup_steps_q <= cfg.data[15:0];
				pidtw_pkg::REG_EVAL_STEPS:   eval_steps_q   <= cfg.data[15:0];
				pidtw_pkg::REG_SETTLE_STEPS: settle_steps_q <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			prev_q   <= '0;
			for (int k = 0; k < 3; k++) begin
				gain_q[k]  <= '0;
				trial_q[k] <= '0;
			end
			sel_q    <= pidtw_pkg::GAIN_SEL_RST;
			up_q     <= 1'b0;
			down_q   <= 1'b0;
			psum_q   <= '0;
			best_q   <= {64{1'b1}};
			warm_q   <= '0;
			pcount_q <= '0;
			first_q  <= 1'b1;
			v_s2     <= 1'b0;
		end else begin
			integ_q  <= integ_d;
			if (fire12) begin
				prev_q <= e_s1;
			end
			for (int k = 0; k < 3; k++) begin
				gain_q[k]  <= gain_d[k];
				trial_q[k] <= trial_d[k];
			end
			sel_q    <= sel_d;
			up_q     <= up_d;
			down_q   <= down_d;
			psum_q   <= psum_d;
			best_q   <= best_d;
			warm_q   <= warm_d;
			pcount_q <= pcount_d;
			first_q  <= first_d;
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire12) begin
			delta_s2   <= delta;
			changed_s2 <= twiddle_go;
		end
	end

	// The state registers hold exactly the values left by the item in stage 2.
	assign s2_valid        = v_s2;
	assign s2_data.err     = prev_q;
	assign s2_data.delta   = delta_s2;
	assign s2_data.integ   = integ_q;
	assign s2_data.gain_p  = gain_q[0];
	assign s2_data.gain_i  = gain_q[1];
	assign s2_data.gain_d  = gain_q[2];
	assign s2_data.changed = changed_s2;

`ifndef NO_ASSERTIONS
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fire12 && twiddle_go |=> psum_q == '0)
		else $error("error sum not cleared after a tuning period end");

	a_best_only_falls: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> best_q <= $past(best_q))
		else $error("best period error increased");

	a_down_after_up: assert property (@(posedge clk) disable iff (!arst_n)
		down_q |-> up_q)
		else $error("downward trial recorded without an upward trial");

	a_change_at_period_start: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && changed_s2 |-> pcount_q == '0)
		else $error("gain change flagged away from a period boundary");

	a_gains_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire12 && !cfg_fire |=> $stable(gain_q[0]) && $stable(gain_q[1])
		&& $stable(gain_q[2]))
		else $error("gains moved without a sample or a register write");
`endif

endmodule

// ===== hdl/pidtw_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidtw_drive
// Drive datapath: one stage of gain products, then the fixed-point sum,
// flooring shift and saturation into the result register.
// ----------------------------------------------------------------------------
module pidtw_drive (
	input  logic                clk,
	input  logic                arst_n,
	input  pidtw_pkg::s2_data_t s2_data,
	input  logic                s2_valid,
	output logic                s2_ready,
	pidtw_result_if.source      result
);

	logic               v_s3;
	logic signed [55:0] pa_s3;
	logic signed [56:0] pc_s3;
	logic signed [51:0] px_s3;
	logic signed [52:0] pl_s3;
	pidtw_pkg::gain_t   gp_s3;
	pidtw_pkg::gain_t   gi_s3;
	pidtw_pkg::gain_t   gd_s3;
	logic               changed_s3;

	logic               out_valid_q;
	pidtw_pkg::drive_t  drive_q;
	pidtw_pkg::gain_t   gp_q;
	pidtw_pkg::gain_t   gi_q;
	pidtw_pkg::gain_t   gd_q;
	logic               changed_q;

	logic               out_free;
	logic               s3_free;

	logic signed [55:0] pa;
	logic signed [56:0] pc;
	logic signed [51:0] px;
	logic signed [52:0] pl;
	logic signed [59:0] y_sum;
	logic signed [39:0] y_shr;
	logic signed [52:0] total;
	logic signed [48:0] total_shr;

	assign out_free = !out_valid_q || result.ready;
	assign s3_free  = !v_s3 || out_free;
	assign s2_ready = s3_free;

	// The integral product is split at bit 20 to keep each multiplier narrow.
	assign pa = $signed(s2_data.gain_p) * $signed(s2_data.err);
	assign pc = $signed(s2_data.gain_d) * $signed(s2_data.delta);
	assign px = $signed(s2_data.gain_i) * $signed(s2_data.integ[39:20]);
	assign pl = $signed(s2_data.gain_i) * $signed({1'b0, s2_data.integ[19:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && s2_valid) begin
			pa_s3      <= pa;
			pc_s3      <= pc;
			px_s3      <= px;
			pl_s3      <= pl;
			gp_s3      <= s2_data.gain_p;
			gi_s3      <= s2_data.gain_i;
			gd_s3      <= s2_data.gain_d;
			changed_s3 <= s2_data.changed;
		end
	end

	// Arithmetic shifts give the floor of each partial sum.
	assign y_sum     = 60'(pl_s3) + 60'(pa_s3) + 60'(pc_s3);
	assign y_shr     = y_sum[59:20];
	assign total     = 53'(px_s3) + 53'(y_shr);
	assign total_shr = total[52:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s3) begin
			drive_q   <= pidtw_pkg::sat_to_32(64'(total_shr));
			gp_q      <= gp_s3;
			gi_q      <= gi_s3;
			gd_q      <= gd_s3;
			changed_q <= changed_s3;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.drive         = drive_q;
	assign result.gain_p        = gp_q;
	assign result.gain_i        = gi_q;
	assign result.gain_d        = gd_q;
	assign result.gains_changed = changed_q;

endmodule

// ===== hdl/pid_controller_with_twiddle_tuning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_with_twiddle_tuning
// PID controller on Q8.16 error samples with twiddle tuning of its gains.
// ----------------------------------------------------------------------------
// The block takes one error sample per clock while the result side does not
// stall, and returns one result per sample. A sample passes in order through
// the input register, the state update, the gain products and the result
// register. The one-per-clock rate is set by the state update stage, where
// the integral, period counters, squared error sum and a full twiddle step on
// one gain are all resolved combinationally and fed back for the next sample.
// Each result carries the saturated Q16.16 drive computed with the gains as
// they stand after that sample's tuning, the three gains themselves, and a
// flag that the sample closed a tuning period with tuning switched on.
// Register writes are taken at any time on the configuration channel but
// belong to quiet periods with no samples in flight; writing a start gain
// also resets that gain's trial step to a tenth of it.
// ----------------------------------------------------------------------------
module pid_controller_with_twiddle_tuning (
	input  logic            clk,
	input  logic            arst_n,
	pidtw_sample_if.sink    sample,
	pidtw_cfg_if.sink       cfg,
	pidtw_result_if.source  result
);

	pidtw_pkg::s2_data_t s2_data;
	logic                s2_valid;
	logic                s2_ready;

	pidtw_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.cfg      (cfg),
		.s2_data  (s2_data),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready)
	);

	pidtw_drive u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_data  (s2_data),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.result   (result)
	);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PID controller with twiddle gain tuning.
// ----------------------------------------------------------------------------
// A short table of directed samples and register writes runs first. It covers
// the gain and error extremes, the first tuning period, tuning switched off,
// a period shortened under its current position and a warm-up raised again.
// Random segments with fresh settings follow, under three handshake profiles.
// Every result is checked: on checked table rows against the table, else
// against an in-bench model of the integral, periods and twiddle search.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		pidtw_pkg::drive_t drive;
		pidtw_pkg::gain_t  gain_p;
		pidtw_pkg::gain_t  gain_i;
		pidtw_pkg::gain_t  gain_d;
		logic              gains_changed;
	} pid_result_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_SAMPLE,
		ROW_CHECKED
	} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		pidtw_pkg::cfg_idx_t index;
		logic [31:0]         value;
		pid_result_t         want;
	} plan_row_t;

	localparam int                   RUN_LIMIT_NS = 2_000_000;
	localparam int                   SEG_ITEMS = 170;
	localparam int                   LONG_HOLD_CYCLES = 300;
	localparam int                   QUIET_CYCLES = 8;
	localparam pidtw_pkg::cfg_idx_t  NO_SUCH_REG = 3'd7;
	localparam pidtw_pkg::err_t      ERR_MAX = 24'sh7F_FFFF;
	localparam pidtw_pkg::err_t      ERR_MIN = 24'sh80_0000;
	localparam pidtw_pkg::cfg_data_t ONE_Q24 = 32'h0100_0000;
	localparam longint               INTEG_HI = 64'sd549755813887;
	localparam longint               INTEG_LO = -64'sd549755813888;

	logic clk;
	logic arst_n;

	pidtw_sample_if sample_ch ();
	pidtw_cfg_if    cfg_ch ();
	pidtw_result_if result_ch ();

	pid_controller_with_twiddle_tuning u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	// Controller model: settings and state.
	logic              tune_on;
	logic [15:0]       warm_len, eval_len, settle_len;
	pidtw_pkg::integ_t integ_acc;
	pidtw_pkg::err_t   last_err;
	pidtw_pkg::gain_t  gain_now [3];
	pidtw_pkg::gain_t  trial [3];
	logic [1:0]        sel_gain;
	logic              up_done, down_done;
	logic [63:0]       sq_sum, best_sq;
	logic [15:0]       warm_count;
	logic [16:0]       pos_count;
	logic              first_pass;

	pid_result_t pending_results [$];
	plan_row_t   plan [$];

	int mismatches = 0;
	int samples_sent = 0;
	int writes_done = 0;
	int results_seen = 0;
	int period_ends = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int holds_requested = 0;
	int holds_started = 0;
	int hold_left = 0;

	function automatic pidtw_pkg::gain_t clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return pidtw_pkg::gain_t'(v);
	endfunction

	function automatic logic [1:0] next_gain(input logic [1:0] s);
		return (s >= 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	function automatic void load_start(input int k, input pidtw_pkg::cfg_data_t v);
		gain_now[k] = pidtw_pkg::gain_t'(v);
		trial[k] = pidtw_pkg::gain_t'(longint'(pidtw_pkg::gain_t'(v)) / 10);
	endfunction

	function automatic void reset_model();
		tune_on = pidtw_pkg::TUNE_ENABLE_RST;
		warm_len = pidtw_pkg::WARMUP_STEPS_RST;
		eval_len = pidtw_pkg::EVAL_STEPS_RST;
		settle_len = pidtw_pkg::SETTLE_STEPS_RST;
		integ_acc = '0;
		last_err = '0;
		for (int k = 0; k < 3; k++) begin
			load_start(k, '0);
		end
		sel_gain = pidtw_pkg::GAIN_SEL_RST;
		up_done = 1'b0;
		down_done = 1'b0;
		sq_sum = '0;
		best_sq = '1;
		warm_count = '0;
		pos_count = '0;
		first_pass = 1'b1;
	endfunction

	function automatic void apply_register(input pidtw_pkg::cfg_idx_t idx,
		input pidtw_pkg::cfg_data_t v);
		case (idx)
			pidtw_pkg::REG_KP_START:     load_start(0, v);
			pidtw_pkg::REG_KI_START:     load_start(1, v);
			pidtw_pkg::REG_KD_START:     load_start(2, v);
			pidtw_pkg::REG_TUNE_ENABLE:  tune_on = v[0];
			pidtw_pkg::REG_WARMUP_STEPS: warm_len = v[15:0];
			pidtw_pkg::REG_EVAL_STEPS:   eval_len = v[15:0];
			pidtw_pkg::REG_SETTLE_STEPS: settle_len = v[15:0];
			default: ;
		endcase
	endfunction

	// One twiddle move at a period end: try up, then down, then restore.
	function automatic void twiddle_gains();
		logic [1:0] s;
		if (sq_sum < best_sq) begin
			best_sq = sq_sum;
			// A best found at the very first period end keeps its step size.
			if (!first_pass) begin
				trial[sel_gain] = clamp32(longint'(trial[sel_gain]) * 11 / 10);
			end
			sel_gain = next_gain(sel_gain);
			up_done = 1'b0;
			down_done = 1'b0;
		end
		s = sel_gain;
		if (!up_done && !down_done) begin
			gain_now[s] = clamp32(longint'(gain_now[s]) + longint'(trial[s]));
			up_done = 1'b1;
		end else if (up_done && !down_done) begin
			gain_now[s] = clamp32(longint'(gain_now[s]) - 2 * longint'(trial[s]));
			down_done = 1'b1;
		end else begin
			gain_now[s] = clamp32(longint'(gain_now[s]) + longint'(trial[s]));
			trial[s] = clamp32(longint'(trial[s]) * 9 / 10);
			sel_gain = next_gain(s);
			up_done = 1'b0;
			down_done = 1'b0;
		end
		sq_sum = '0;
	endfunction

	function automatic pid_result_t step_controller(input pidtw_pkg::err_t e);
		longint      ev, d, acc, a, c, sh, sl, x, y;
		logic [31:0] len, pos;
		logic [63:0] sq, t;
		pid_result_t r;
		r = '0;
		ev = e;
		acc = longint'(integ_acc) + ev;
		if (acc > INTEG_HI) begin
			acc = INTEG_HI;
		end
		if (acc < INTEG_LO) begin
			acc = INTEG_LO;
		end
		integ_acc = pidtw_pkg::integ_t'(acc);
		d = ev - longint'(last_err);
		last_err = e;
		if (warm_count < warm_len) begin
			warm_count++;
		end else begin
			len = {16'd0, settle_len} + {16'd0, eval_len};
			pos = {15'd0, pos_count} + 32'd1;
			if (pos >= len) begin
				pos = '0;
			end
			pos_count = pos[16:0];
			if (pos > {16'd0, settle_len}) begin
				sq = ev * ev;
				t = sq_sum + sq;
				sq_sum = (t < sq_sum) ? '1 : t;
			end
			if (pos == '0) begin
				if (tune_on) begin
					twiddle_gains();
					r.gains_changed = 1'b1;
				end
				first_pass = 1'b0;
			end
		end
		// The integral term is split so that every partial product stays exact.
		a = longint'(gain_now[0]) * ev;
		c = longint'(gain_now[2]) * d;
		sh = acc >>> 20;
		sl = acc & 64'sh0000_0000_000F_FFFF;
		x = longint'(gain_now[1]) * sh;
		y = longint'(gain_now[1]) * sl + a + c;
		r.drive = clamp32((x + (y >>> 20)) >>> 4);
		r.gain_p = gain_now[0];
		r.gain_i = gain_now[1];
		r.gain_d = gain_now[2];
		return r;
	endfunction

	function automatic plan_row_t plan_step(input row_kind_t kind,
		input pidtw_pkg::cfg_idx_t idx, input logic [31:0] value, input pid_result_t want);
		plan_row_t row;
		row.kind = kind;
		row.index = idx;
		row.value = value;
		row.want = want;
		return row;
	endfunction

	function automatic pidtw_pkg::err_t draw_error();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return pidtw_pkg::err_t'($urandom);
		end
		if (pick < 85) begin
			return pidtw_pkg::err_t'(int'($urandom_range(0, 512)) - 256);
		end
		if (pick < 95) begin
			return $urandom_range(0, 1) ? ERR_MAX : ERR_MIN;
		end
		return '0;
	endfunction

	function automatic pidtw_pkg::cfg_data_t draw_gain(input bit extreme);
		int pick;
		if (extreme) begin
			pick = $urandom_range(0, 2);
			return (pick == 0) ? pidtw_pkg::GAIN_MAX :
				(pick == 1) ? pidtw_pkg::GAIN_MIN : '0;
		end
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return pidtw_pkg::cfg_data_t'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
		end
		if (pick == 6) begin
			return pidtw_pkg::GAIN_MAX;
		end
		if (pick == 7) begin
			return pidtw_pkg::GAIN_MIN;
		end
		if (pick == 8) begin
			return $urandom;
		end
		return '0;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch on %s: expected %h, got %h", name, want, got);
			end
		end
	endfunction

	task automatic send_sample(input pidtw_pkg::err_t e, input bit typed,
		input pid_result_t typed_want);
		int          gap;
		pid_result_t predicted;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.error_sample <= e;
		do @(posedge clk); while (!sample_ch.ready);
		predicted = step_controller(e);
		pending_results.push_back(typed ? typed_want : predicted);
		samples_sent++;
	endtask

	// Stops offering samples and waits until the block has nothing left in flight.
	task automatic drain_results(input int extra_cycles);
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic write_register(input pidtw_pkg::cfg_idx_t idx,
		input pidtw_pkg::cfg_data_t v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_register(idx, v);
		writes_done++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Short periods most of the time so that the twiddle search gets deep.
	task automatic load_settings(input bit extreme);
		drain_results(QUIET_CYCLES);
		write_register(pidtw_pkg::REG_KP_START, draw_gain(extreme));
		write_register(pidtw_pkg::REG_KI_START, draw_gain(extreme));
		write_register(pidtw_pkg::REG_KD_START, draw_gain(extreme));
		if (extreme) begin
			write_register(pidtw_pkg::REG_TUNE_ENABLE,
				pidtw_pkg::cfg_data_t'($urandom_range(0, 1)));
			write_register(pidtw_pkg::REG_WARMUP_STEPS,
				$urandom_range(0, 1) ? 32'd0 : 32'd65535);
			write_register(pidtw_pkg::REG_EVAL_STEPS,
				$urandom_range(0, 1) ? 32'd1 : 32'd65535);
			write_register(pidtw_pkg::REG_SETTLE_STEPS,
				$urandom_range(0, 1) ? 32'd0 : 32'd65535);
		end else begin
			write_register(pidtw_pkg::REG_TUNE_ENABLE,
				pidtw_pkg::cfg_data_t'($urandom_range(0, 5) != 0));
			write_register(pidtw_pkg::REG_WARMUP_STEPS,
				pidtw_pkg::cfg_data_t'($urandom_range(0, 30)));
			write_register(pidtw_pkg::REG_EVAL_STEPS,
				pidtw_pkg::cfg_data_t'($urandom_range(1, 24)));
			write_register(pidtw_pkg::REG_SETTLE_STEPS,
				pidtw_pkg::cfg_data_t'($urandom_range(0, 6)));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("testbench NOT OK");
		$finish;
	end

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_started != holds_requested) begin
				holds_started++;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		pid_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (result_ch.gains_changed) begin
				period_ends++;
			end
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result with none expected: drive %h", result_ch.drive);
				end
			end else begin
				want = pending_results.pop_front();
				check_field("drive", want.drive, result_ch.drive);
				check_field("gain_p", want.gain_p, result_ch.gain_p);
				check_field("gain_i", want.gain_i, result_ch.gain_i);
				check_field("gain_d", want.gain_d, result_ch.gain_d);
				check_field("gains_changed", {31'd0, want.gains_changed},
					{31'd0, result_ch.gains_changed});
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.error_sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		reset_model();

		// After reset every gain is zero, so any sample drives zero.
		plan.push_back(plan_step(ROW_CHECKED, '0, ERR_MAX, '0));
		plan.push_back(plan_step(ROW_CHECKED, '0, ERR_MIN, '0));
		// A unit proportional gain passes the error straight through.
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_KP_START, ONE_Q24, '0));
		plan.push_back(plan_step(ROW_CHECKED, '0, ERR_MAX,
			'{32'h007F_FFFF, ONE_Q24, 32'h0, 32'h0, 1'b0}));
		plan.push_back(plan_step(ROW_CHECKED, '0, ERR_MIN,
			'{32'hFF80_0000, ONE_Q24, 32'h0, 32'h0, 1'b0}));
		plan.push_back(plan_step(ROW_CHECKED, '0, 32'h0,
			'{32'h0, ONE_Q24, 32'h0, 32'h0, 1'b0}));
		// Gain extremes, applied to the largest and smallest error samples.
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_KP_START, pidtw_pkg::GAIN_MAX, '0));
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_KI_START, pidtw_pkg::GAIN_MAX, '0));
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_KD_START, pidtw_pkg::GAIN_MIN, '0));
		plan.push_back(plan_step(ROW_SAMPLE, '0, ERR_MAX, '0));
		plan.push_back(plan_step(ROW_SAMPLE, '0, ERR_MIN, '0));
		// Warm-up dropped below the count: periods of one sample start at once,
		// and the first of them is tuned without growing the step.
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_WARMUP_STEPS, 32'd0, '0));
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_EVAL_STEPS, 32'd1, '0));
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_SETTLE_STEPS, 32'd0, '0));
		plan.push_back(plan_step(ROW_WRITE, NO_SUCH_REG, 32'hFFFF_FFFF, '0));
		plan.push_back(plan_step(ROW_SAMPLE, '0, 32'h00_1234, '0));
		plan.push_back(plan_step(ROW_SAMPLE, '0, 32'hFF_F000, '0));
		// Tuning off: period ends leave the gains alone.
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_TUNE_ENABLE, 32'd0, '0));
		plan.push_back(plan_step(ROW_SAMPLE, '0, 32'h40_0000, '0));
		plan.push_back(plan_step(ROW_SAMPLE, '0, 32'hC0_0000, '0));
		// Tuning back on: up, down and restore moves on one gain after another.
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_TUNE_ENABLE, 32'd1, '0));
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_KP_START, ONE_Q24, '0));
		for (int k = 0; k < 4; k++) begin
			plan.push_back(plan_step(ROW_SAMPLE, '0, 32'h00_0100 << k, '0));
		end
		// Longest period, then one shortened under the current position.
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_EVAL_STEPS, 32'd65535, '0));
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_SETTLE_STEPS, 32'd65535, '0));
		for (int k = 0; k < 3; k++) begin
			plan.push_back(plan_step(ROW_SAMPLE, '0, 32'h12_3456, '0));
		end
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_EVAL_STEPS, 32'd2, '0));
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_SETTLE_STEPS, 32'd1, '0));
		for (int k = 0; k < 3; k++) begin
			plan.push_back(plan_step(ROW_SAMPLE, '0, 32'hED_CBA9, '0));
		end
		// Warm-up raised above the count puts the block back into warm-up.
		plan.push_back(plan_step(ROW_WRITE, pidtw_pkg::REG_WARMUP_STEPS, 32'd65535, '0));
		plan.push_back(plan_step(ROW_SAMPLE, '0, 32'h55_AA55, '0));

		tx_idle_pct = 12;
		rx_idle_pct = 54;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				drain_results(QUIET_CYCLES);
				write_register(plan[i].index, plan[i].value);
			end else begin
				send_sample(pidtw_pkg::err_t'(plan[i].value[23:0]),
					plan[i].kind == ROW_CHECKED, plan[i].want);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 12;
					rx_idle_pct = 54;
				end
				1: begin
					tx_idle_pct = 54;
					rx_idle_pct = 12;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				load_settings(seg == 3);
				for (int n = 0; n < SEG_ITEMS; n++) begin
					// Long result stall while samples keep coming, so the input backs up.
					if (seg == 1 && n == 60) begin
						holds_requested++;
					end
					if (seg == 2 && n == 80) begin
						drain_results(0);
					end
					send_sample(draw_error(), 1'b0, '0);
				end
			end
		end

		drain_results(4 * QUIET_CYCLES);
		$display("Ran %0d error samples and %0d register writes under three stall profiles.",
			samples_sent, writes_done);
		$display("Checked %0d results, %0d of them at the end of a tuning period.",
			results_seen, period_ends);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
